// File: rtl/assert_macros.svh
// Assertion helpers for the RTL, included by argsort_index_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// File: rtl/aie_pkg.sv
package aie_pkg;

   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int VALUE_BITS_DEF   = 32;
   localparam int SAMPLE_BITS      = 32;
   localparam int POS_BITS         = 6;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic                          final_item;
   } req_type;

   typedef struct packed {
      logic [POS_BITS-1:0]           original_position;
      logic signed [SAMPLE_BITS-1:0] ranked_value;
      logic                          final_result;
      logic                          overflow_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_SORT,
      OP_EMIT
   } chain_op_type;

   typedef struct packed {
      chain_op_type op;
      logic         phase;
      logic         ascending;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/aie_cell.sv
module aie_cell #(
   parameter int VALUE_BITS = aie_pkg::VALUE_BITS_DEF,
   parameter bit ODD_SLOT   = 1'b0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  aie_pkg::chain_ctl_type         ctl,
   input  logic                           left_valid,
   input  logic signed [VALUE_BITS-1:0]   left_value,
   input  logic [aie_pkg::POS_BITS-1:0]   left_pos,
   input  logic                           left_swap,
   input  logic                           right_valid,
   input  logic signed [VALUE_BITS-1:0]   right_value,
   input  logic [aie_pkg::POS_BITS-1:0]   right_pos,
   output logic                           cell_valid,
   output logic signed [VALUE_BITS-1:0]   cell_value,
   output logic [aie_pkg::POS_BITS-1:0]   cell_pos,
   output logic                           swap_right
);

   logic                         valid_ff, valid_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [aie_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic                         right_first;
   logic                         take_left, take_right;

   // Arrival position breaks ties, which keeps the order stable.
   always_comb begin
      if (ctl.ascending) begin
         right_first = (right_value < value_ff) ||
                       ((right_value == value_ff) && (right_pos < pos_ff));
      end else begin
         right_first = (right_value > value_ff) ||
                       ((right_value == value_ff) && (right_pos < pos_ff));
      end
   end

   assign swap_right = right_valid && valid_ff && right_first;

   always_comb begin
      take_left  = 1'b0;
      take_right = 1'b0;
      case (ctl.op)
         aie_pkg::OP_LOAD: take_left = 1'b1;
         aie_pkg::OP_EMIT: take_right = 1'b1;
         aie_pkg::OP_SORT: begin
            // Left member of the pair this phase: look right, else look left.
            if (ctl.phase == ODD_SLOT) begin
               take_right = swap_right;
            end else begin
               take_left = left_swap;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (take_left) begin
         valid_in = left_valid;
         value_in = left_value;
         pos_in   = left_pos;
      end else if (take_right) begin
         valid_in = right_valid;
         value_in = right_value;
         pos_in   = right_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign cell_valid = valid_ff;
   assign cell_value = value_ff;
   assign cell_pos   = pos_ff;

endmodule

// File: rtl/argsort_index_engine.sv
// Argsort engine: ranks a set of signed values and returns their arrival positions.
// req channel: one value per beat; final_item closes the set. Values load into a
//   chain of cells at one beat per cycle while the chain is not full; beats past
//   MAX_ELEMENTS are dropped and flagged on the last result.
// csr port: csr_write_data sets sort_ascending (1 = smallest first); it is sampled
//   when the final beat is accepted.
// After the final beat the chain runs odd-even transposition over the n stored
//   values, then rsp delivers n beats, rank order, one per cycle while rsp_ready
//   is high. Each beat carries original_position and ranked_value; the last beat
//   sets final_result and overflow_seen. Ties keep arrival order.
// A set thus goes through load, sort and result phases in that order; the sort
//   is carried out by transposition passes over the cell chain.
// req_ready is low from the final beat until the last result beat is taken.
// A stalled rsp holds the head result in the first cell; nothing moves until taken.
// Reset (synchronous) empties the chain, clears the count and overflow flag and
//   sets sort_ascending to 1.
`include "assert_macros.svh"

module argsort_index_engine #(
   parameter int MAX_ELEMENTS = aie_pkg::MAX_ELEMENTS_DEF,
   parameter int VALUE_BITS   = aie_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aie_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aie_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   aie_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          sort_cnt_ff, sort_cnt_in;
   logic                   ovf_ff, ovf_in;
   logic                   csr_up_ff;
   logic                   sort_up_ff, sort_up_in;
   aie_pkg::chain_ctl_type ctl;

   logic                   req_beat, rsp_beat, has_room;
   logic signed [VALUE_BITS-1:0] new_value;
   logic [aie_pkg::POS_BITS-1:0] new_pos;

   logic                         c_valid [MAX_ELEMENTS];
   logic signed [VALUE_BITS-1:0] c_value [MAX_ELEMENTS];
   logic [aie_pkg::POS_BITS-1:0] c_pos   [MAX_ELEMENTS];
   logic                         c_swap  [MAX_ELEMENTS];

   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;
   assign has_room  = count_ff < CW'(MAX_ELEMENTS);
   assign new_value = VALUE_BITS'(req_payload.sample_value);
   assign new_pos   = aie_pkg::POS_BITS'(count_ff);

   // Next state
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      sort_cnt_in = sort_cnt_ff;
      ovf_in      = ovf_ff;
      sort_up_in  = sort_up_ff;
      case (state_ff)
         aie_pkg::ST_LOAD: begin
            if (req_beat) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.final_item) begin
                  state_in    = aie_pkg::ST_SORT;
                  sort_cnt_in = '0;
                  sort_up_in  = csr_up_ff;
               end
            end
         end
         aie_pkg::ST_SORT: begin
            sort_cnt_in = sort_cnt_ff + CW'(1);
            if (sort_cnt_ff == count_ff - CW'(1)) begin
               state_in = aie_pkg::ST_EMIT;
            end
         end
         aie_pkg::ST_EMIT: begin
            if (rsp_beat) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = aie_pkg::ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: state_in = aie_pkg::ST_LOAD;
      endcase
   end

   // Outputs and chain control
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      ctl.op        = aie_pkg::OP_HOLD;
      ctl.phase     = sort_cnt_ff[0];
      ctl.ascending = sort_up_ff;
      case (state_ff)
         aie_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_beat && has_room) begin
               ctl.op = aie_pkg::OP_LOAD;
            end
         end
         aie_pkg::ST_SORT: ctl.op = aie_pkg::OP_SORT;
         aie_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_beat) begin
               ctl.op = aie_pkg::OP_EMIT;
            end
         end
         default: ;
      endcase
   end

   assign rsp_payload.original_position = c_pos[0];
   assign rsp_payload.ranked_value      = aie_pkg::SAMPLE_BITS'(c_value[0]);
   assign rsp_payload.final_result      = (count_ff == CW'(1));
   assign rsp_payload.overflow_seen     = (count_ff == CW'(1)) && ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= aie_pkg::ST_LOAD;
         count_ff    <= '0;
         sort_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         csr_up_ff   <= 1'b1;
         sort_up_ff  <= 1'b1;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         sort_cnt_ff <= sort_cnt_in;
         ovf_ff      <= ovf_in;
         sort_up_ff  <= sort_up_in;
         if (csr_write_enable) begin
            csr_up_ff <= csr_write_data;
         end
      end
   end

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic                         l_valid, r_valid, l_swap;
      logic signed [VALUE_BITS-1:0] l_value, r_value;
      logic [aie_pkg::POS_BITS-1:0] l_pos, r_pos;

      if (i == 0) begin : g_head
         assign l_valid = 1'b1;
         assign l_value = new_value;
         assign l_pos   = new_pos;
         assign l_swap  = 1'b0;
      end else begin : g_mid
         assign l_valid = c_valid[i-1];
         assign l_value = c_value[i-1];
         assign l_pos   = c_pos[i-1];
         assign l_swap  = c_swap[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_value = '0;
         assign r_pos   = '0;
      end else begin : g_body
         assign r_valid = c_valid[i+1];
         assign r_value = c_value[i+1];
         assign r_pos   = c_pos[i+1];
      end

      aie_cell #(
         .VALUE_BITS (VALUE_BITS),
         .ODD_SLOT   (1'(i % 2))
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_valid  (l_valid),
         .left_value  (l_value),
         .left_pos    (l_pos),
         .left_swap   (l_swap),
         .right_valid (r_valid),
         .right_value (r_value),
         .right_pos   (r_pos),
         .cell_valid  (c_valid[i]),
         .cell_value  (c_value[i]),
         .cell_pos    (c_pos[i]),
         .swap_right  (c_swap[i])
      );
   end

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_ELEMENTS))
   `ASSERT_IMPLIES(a_head_loaded, clock, reset, rsp_valid, c_valid[0])
   `ASSERT_NEXT(a_final_sorts, clock, reset, req_beat && req_payload.final_item,
      state_ff == aie_pkg::ST_SORT)
   `ASSERT_NEXT(a_last_frees, clock, reset, rsp_beat && rsp_payload.final_result,
      req_ready && !c_valid[0])

endmodule
